/* hw/rtl/tlvd_pkg.sv */
// Shared types and constants of the TLV frame deframer.
// No dependencies; every other file of the block but tlvd_req_if imports this package.
`default_nettype none

package tlvd_pkg;

   // Frame header layout.
   localparam int unsigned HEADER_BYTES = 13;
   localparam logic [3:0] HDR_IDX_LAST   = 4'(HEADER_BYTES - 1);
   localparam logic [3:0] HDR_IDX_MAGIC  = 4'd2;   // indexes below this hold the magic
   localparam logic [3:0] HDR_IDX_COUNT  = 4'd4;
   localparam logic [3:0] HDR_IDX_LEN0   = 4'd9;   // first byte of the payload length

   // Field header layout: id, then the value length high and low bytes.
   localparam logic [1:0] FHDR_IDX_LEN_HI = 2'd1;
   localparam logic [1:0] FHDR_IDX_LEN_LO = 2'd2;

   typedef logic [2:0] section_type;

   localparam section_type SEC_HEADER  = 3'd0;
   localparam section_type SEC_FHDR    = 3'd1;
   localparam section_type SEC_FVAL    = 3'd2;
   localparam section_type SEC_PAYLOAD = 3'd3;
   localparam section_type SEC_DEAD    = 3'd4;

   typedef struct packed {
      logic [7:0]  byte_out;
      section_type section;
      logic [7:0]  field_number;
      logic        frame_end;
      logic        bad_magic;
      logic        dead;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/tlvd_req_if.sv */
// Input channel of the TLV frame deframer: one received byte per transaction.
// Depends on nothing.
`default_nettype none

interface tlvd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tlvd_rsp_if.sv */
// Result channel of the TLV frame deframer: one tagged byte per transaction.
// Depends on tlvd_pkg for the section type.
`default_nettype none

interface tlvd_rsp_if
   import tlvd_pkg::*;
   ;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_out;
   section_type section;
   logic [7:0]  field_number;
   logic        frame_end;
   logic        bad_magic;
   logic        dead;

   modport source (output valid, output byte_out, output section, output field_number,
                   output frame_end, output bad_magic, output dead, input ready);
   modport sink   (input valid, input byte_out, input section, input field_number,
                   input frame_end, input bad_magic, input dead, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tlv_frame_deframer_core.sv */
// TLV frame deframer, top level: byte channels, magic register and result register.
// Depends on tlvd_pkg, tlvd_req_if, tlvd_rsp_if and tlvd_parser.
//
// Usage:
//   req_if carries one received byte per transaction; rsp_if returns the same
//   byte tagged with its section (header, field header, field value, payload,
//   or dropped), its field number, a frame-end mark, a bad-magic mark and the
//   dead flag. Every input transaction yields exactly one result transaction.
//   csr_wr_en/csr_wr_data write the expected 16-bit frame magic; write it only
//   while no byte is in flight.
//   The result of an accepted byte is registered and offered on rsp_if in the
//   cycle after the byte is accepted. Throughput is one byte per cycle while the
//   receiver takes each result; the only storage between the channels is the
//   result register, and the parse counters update in the same cycle a byte is accepted.
//   When the receiver stalls, the result register holds its transaction and
//   req_if.ready drops until that result is taken; a new byte is accepted in
//   the same cycle the waiting result leaves.
//   Reset clears the parse state, the dead flag and the magic register (to
//   zero). A magic mismatch marks the stream dead; only reset clears it.
`default_nettype none

module tlv_frame_deframer_core
   import tlvd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   tlvd_req_if.sink         req_if,
   tlvd_rsp_if.source       rsp_if,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic [15:0] magic_value_ff;
   logic        rsp_valid_ff;
   result_type  rsp_data_ff;
   result_type  parse_result;
   logic        req_accept;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   tlvd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (req_accept),
      .byte_in     (req_if.byte_in),
      .magic_value (magic_value_ff),
      .result      (parse_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_value_ff <= 16'd0;
      end else if (csr_wr_en) begin
         magic_value_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= parse_result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.byte_out     = rsp_data_ff.byte_out;
   assign rsp_if.section      = rsp_data_ff.section;
   assign rsp_if.field_number = rsp_data_ff.field_number;
   assign rsp_if.frame_end    = rsp_data_ff.frame_end;
   assign rsp_if.bad_magic    = rsp_data_ff.bad_magic;
   assign rsp_if.dead         = rsp_data_ff.dead;

`ifndef NO_ASSERTIONS
   // Every accepted byte produces a result in the following cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted byte did not produce a result");

   // A frame can only end on a byte of a live stream.
   a_frame_end_live: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_end) |->
         (!rsp_data_ff.dead && rsp_data_ff.section != SEC_DEAD))
      else $error("frame end reported on a dead stream");

   // Dropped bytes carry the dead flag and no field number.
   a_dropped_tags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.section == SEC_DEAD) |->
         (rsp_data_ff.dead && rsp_data_ff.field_number == 8'd0 && !rsp_data_ff.bad_magic))
      else $error("dropped byte has inconsistent tags");

   // A magic mismatch is flagged on a header byte and kills the stream at once.
   a_bad_magic_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.bad_magic) |->
         (rsp_data_ff.section == SEC_HEADER && rsp_data_ff.dead))
      else $error("bad magic flagged outside the header or without dead");
`endif

endmodule

`default_nettype wire

/* hw/rtl/tlvd_parser.sv */
// Frame parse state of the TLV deframer and the tag logic for the current byte.
// Depends on tlvd_pkg; the state advances when step is high.
`default_nettype none

module tlvd_parser
   import tlvd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [7:0]  byte_in,
   input  wire logic [15:0] magic_value,
   output result_type       result
);

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_FHDR    = 3'd1;
   localparam logic [2:0] PH_FVAL    = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_DEAD    = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [15:0] magic_ff, magic_in;
   logic [7:0]  fields_ff, fields_in;
   logic [7:0]  field_idx_ff, field_idx_in;
   logic [1:0]  fhdr_idx_ff, fhdr_idx_in;
   logic [15:0] value_ff, value_in;
   logic [31:0] payload_ff, payload_in;
   logic        broken_ff, broken_in;

   always_comb begin
      phase_in     = phase_ff;
      hdr_idx_in   = hdr_idx_ff;
      magic_in     = magic_ff;
      fields_in    = fields_ff;
      field_idx_in = field_idx_ff;
      fhdr_idx_in  = fhdr_idx_ff;
      value_in     = value_ff;
      payload_in   = payload_ff;
      broken_in    = broken_ff;

      result.byte_out     = byte_in;
      result.section      = SEC_DEAD;
      result.field_number = 8'd0;
      result.frame_end    = 1'b0;
      result.bad_magic    = 1'b0;

      if (broken_ff || phase_ff == PH_DEAD) begin
         result.section = SEC_DEAD;
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               result.section = SEC_HEADER;
               if (hdr_idx_ff < HDR_IDX_MAGIC) begin
                  magic_in = {magic_ff[7:0], byte_in};
               end else if (hdr_idx_ff == HDR_IDX_COUNT) begin
                  fields_in = byte_in;
               end else if (hdr_idx_ff >= HDR_IDX_LEN0) begin
                  payload_in = {payload_ff[23:0], byte_in};
               end
               if (hdr_idx_ff >= HDR_IDX_LAST) begin
                  hdr_idx_in = 4'd0;
                  if (magic_in != magic_value) begin
                     result.bad_magic = 1'b1;
                     broken_in        = 1'b1;
                     phase_in         = PH_DEAD;
                  end else if (fields_in != 8'd0) begin
                     field_idx_in = 8'd0;
                     fhdr_idx_in  = 2'd0;
                     phase_in     = PH_FHDR;
                  end else begin
                     field_idx_in = 8'd0;
                     if (payload_in != 32'd0) begin
                        phase_in = PH_PAYLOAD;
                     end else begin
                        phase_in         = PH_HEADER;
                        result.frame_end = 1'b1;
                     end
                  end
               end else begin
                  hdr_idx_in = hdr_idx_ff + 4'd1;
               end
            end
            PH_FHDR, PH_FVAL: begin
               result.field_number = field_idx_ff;
               if (phase_ff == PH_FHDR) begin
                  result.section = SEC_FHDR;
                  if (fhdr_idx_ff == FHDR_IDX_LEN_HI) begin
                     value_in = {byte_in, 8'h00};
                  end else if (fhdr_idx_ff >= FHDR_IDX_LEN_LO) begin
                     value_in = {value_ff[15:8], value_ff[7:0] | byte_in};
                  end
               end else begin
                  result.section = SEC_FVAL;
                  value_in       = value_ff - 16'd1;
               end
               // A field ends after its last value byte, or on its last
               // header byte when the value is empty.
               if ((phase_ff == PH_FHDR && fhdr_idx_ff >= FHDR_IDX_LEN_LO && value_in == 16'd0)
                   || (phase_ff == PH_FVAL && value_in == 16'd0)) begin
                  fhdr_idx_in  = 2'd0;
                  fields_in    = fields_ff - 8'd1;
                  field_idx_in = field_idx_ff + 8'd1;
                  if (fields_in == 8'd0) begin
                     field_idx_in = 8'd0;
                     if (payload_ff != 32'd0) begin
                        phase_in = PH_PAYLOAD;
                     end else begin
                        phase_in         = PH_HEADER;
                        result.frame_end = 1'b1;
                     end
                  end else begin
                     phase_in = PH_FHDR;
                  end
               end else if (phase_ff == PH_FHDR) begin
                  if (fhdr_idx_ff >= FHDR_IDX_LEN_LO) begin
                     fhdr_idx_in = 2'd0;
                     phase_in    = PH_FVAL;
                  end else begin
                     fhdr_idx_in = fhdr_idx_ff + 2'd1;
                  end
               end
            end
            PH_PAYLOAD: begin
               result.section = SEC_PAYLOAD;
               payload_in     = payload_ff - 32'd1;
               if (payload_in == 32'd0) begin
                  phase_in         = PH_HEADER;
                  result.frame_end = 1'b1;
               end
            end
            default: begin
               result.section = SEC_DEAD;
            end
         endcase
      end

      result.dead = broken_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_idx_ff   <= 4'd0;
         magic_ff     <= 16'd0;
         fields_ff    <= 8'd0;
         field_idx_ff <= 8'd0;
         fhdr_idx_ff  <= 2'd0;
         value_ff     <= 16'd0;
         payload_ff   <= 32'd0;
         broken_ff    <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         magic_ff     <= magic_in;
         fields_ff    <= fields_in;
         field_idx_ff <= field_idx_in;
         fhdr_idx_ff  <= fhdr_idx_in;
         value_ff     <= value_in;
         payload_ff   <= payload_in;
         broken_ff    <= broken_in;
      end
   end

endmodule

`default_nettype wire
